// ----- hdl/bae_pkg.sv -----
`default_nettype none

package bae_pkg;

  // command codes of an input transaction
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // bound values
  localparam logic [31:0] LOW_RESET  = 32'h0000_0000;
  localparam logic [31:0] HIGH_RESET = 32'hffff_ffff;
  localparam logic [7:0]  FILL_BYTE  = 8'hff;

  localparam logic [QUEUE_AW:0] MAX_BYTES_M1 = (QUEUE_AW + 1)'(3);

  typedef struct packed {
    logic        command;
    logic [15:0] prob_one;
    logic        bit_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
  } out_item_t;

  // classified work item held in the queue
  typedef struct packed {
    logic        is_finish;
    logic [15:0] prob;
    logic        bit_val;
  } work_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    work_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_SHIFT,
    B_FLUSH
  } back_state_t;

endpackage

`default_nettype wire

// ----- hdl/binary_arithmetic_encoder.sv -----
// binary arithmetic encoder, 32-bit bounds, 16-bit probability of a one
// input channel in_*: one transaction per bit to encode (command encode) or
// one finish transaction that flushes a closing byte and restarts the stream
// output channel out_*: one transaction per compressed byte; last_of_run marks
// the last byte caused by an input transaction, end_of_stream the flush byte
// a four-entry queue sits behind the input, so in_ready stays high while it
// has room and up to four transactions are taken back to back
// back end steps per queued transaction: encode pops it, forms the
// two partial-product multiplies, does the midpoint add and then emits the
// resulting bytes (0 to 4); finish pops it and emits the flush byte
// the back end sequencer handles one transaction at a time and takes the
// next queued transaction only once it is through with the last one
// reset (rst_n low at a clock edge) empties the queue, drops any pending byte
// and returns the bounds to low = 0, high = all ones
// when the receiver stalls the byte waits in the output register; the back
// end stops while it is full and the queue then fills and drops in_ready
`default_nettype none

module binary_arithmetic_encoder (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bae_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bae_pkg::out_item_t  out_data
);
  import bae_pkg::*;

  queue_head_t head;
  logic        pop;

  // front: classifies input transactions and queues them
  bae_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  // back: interval split, renormalization and byte output
  bae_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/bae_front.sv -----
`default_nettype none

module bae_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  bae_pkg::in_item_t     in_data,
  output bae_pkg::queue_head_t  head,
  input  wire                   pop
);
  import bae_pkg::*;

  work_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                push;
  logic                do_pop;
  work_t               classified;

  // classify the incoming transaction
  always_comb begin
    classified.is_finish = (in_data.command == CMD_FINISH);
    classified.prob      = in_data.prob_one;
    classified.bit_val   = in_data.bit_value;
  end

  assign in_ready = (count_r != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bae_back.sv -----
`default_nettype none

module bae_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  bae_pkg::queue_head_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output bae_pkg::out_item_t    out_data
);
  import bae_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [31:0]       low_r, low_nxt;
  logic [31:0]       high_r, high_nxt;
  logic [15:0]       prob_r, prob_nxt;
  logic              bit_r, bit_nxt;
  logic [31:0]       phi_r, phi_nxt;
  logic [15:0]       plo_r, plo_nxt;
  logic [QUEUE_AW:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [31:0] width;
  logic [31:0] lo_prod;
  logic [31:0] mid;
  logic        slot_free;
  logic        agree;
  logic        last_byte;

  assign width     = high_r - low_r;
  assign lo_prod   = {16'b0, width[15:0]} * {16'b0, prob_r};
  assign mid       = low_r + phi_r + {16'b0, plo_r};
  assign slot_free = !out_valid_r || out_ready;
  assign agree     = (low_r[31:24] == high_r[31:24]);
  assign last_byte = (cnt_r == MAX_BYTES_M1) || (low_r[23:16] != high_r[23:16]);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    prob_nxt      = prob_r;
    bit_nxt       = bit_r;
    phi_nxt       = phi_r;
    plo_nxt       = plo_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          prob_nxt  = head.item.prob;
          bit_nxt   = head.item.bit_val;
          state_nxt = head.item.is_finish ? B_FLUSH : B_MUL;
        end
      end
      B_MUL: begin
        // partial products of the interval width with the probability
        phi_nxt   = {16'b0, width[31:16]} * {16'b0, prob_r};
        plo_nxt   = lo_prod[31:16];
        state_nxt = B_ADD;
      end
      B_ADD: begin
        if (bit_r) begin
          high_nxt = mid;
        end else begin
          low_nxt = mid + 32'd1;
        end
        cnt_nxt   = '0;
        state_nxt = B_SHIFT;
      end
      B_SHIFT: begin
        if (!agree) begin
          state_nxt = B_IDLE;
        end else if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_byte      = high_r[31:24];
          out_data_nxt.last_of_run   = last_byte;
          out_data_nxt.end_of_stream = 1'b0;
          low_nxt  = {low_r[23:0], 8'h00};
          high_nxt = {high_r[23:0], FILL_BYTE};
          cnt_nxt  = cnt_r + 1'b1;
          if (last_byte) begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_byte      = high_r[31:24];
          out_data_nxt.last_of_run   = 1'b1;
          out_data_nxt.end_of_stream = 1'b1;
          low_nxt   = LOW_RESET;
          high_nxt  = HIGH_RESET;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      low_r       <= LOW_RESET;
      high_r      <= HIGH_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prob_r     <= prob_nxt;
    bit_r      <= bit_nxt;
    phi_r      <= phi_nxt;
    plo_r      <= plo_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
